>>> rtl/odrgb_pkg.sv
package odrgb_pkg;

    // Field widths of the pixel word and the result word.
    localparam int COORD_W   = 12;
    localparam int CHAN_W    = 8;
    localparam int LEVELS_W  = 9;

    // Only the low COORD_BITS bits of each coordinate select a threshold.
    localparam int COORD_BITS = 12;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((33'd1 << COORD_BITS) - 33'd1);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS   = 1'b1;

    // Threshold map selector codes.
    localparam logic [1:0] MAP_2X2 = 2'd0;
    localparam logic [1:0] MAP_3X3 = 2'd1;
    localparam logic [1:0] MAP_4X4 = 2'd2;
    localparam logic [1:0] MAP_6X6 = 2'd3;

    localparam int THR_W = 6;
    localparam int NN2_W = 7;

    // Threshold maps, each padded with zeros to 6x6.
    localparam logic [THR_W-1:0] THR_TAB [4][6][6] = '{
        '{'{6'd0, 6'd2, 6'd0, 6'd0, 6'd0, 6'd0},
          '{6'd3, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0},
          '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
          '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
          '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
          '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}},
        '{'{6'd6, 6'd8, 6'd4, 6'd0, 6'd0, 6'd0},
          '{6'd1, 6'd0, 6'd3, 6'd0, 6'd0, 6'd0},
          '{6'd5, 6'd2, 6'd7, 6'd0, 6'd0, 6'd0},
          '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
          '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
          '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0}},
        '{'{6'd0,  6'd8,  6'd2,  6'd10, 6'd0, 6'd0},
          '{6'd12, 6'd4,  6'd14, 6'd6,  6'd0, 6'd0},
          '{6'd3,  6'd11, 6'd1,  6'd9,  6'd0, 6'd0},
          '{6'd15, 6'd7,  6'd13, 6'd5,  6'd0, 6'd0},
          '{6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
          '{6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0}},
        '{'{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34},
          '{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18},
          '{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46},
          '{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30},
          '{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33},
          '{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17}}
    };

    typedef struct packed {
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
        logic [CHAN_W-1:0]  red_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  blue_in;
    } odrgb_pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
    } odrgb_result_t;

    // Per-pixel values shared by all channel lanes.
    typedef struct packed {
        logic [THR_W-1:0]    thr;   // threshold t
        logic [NN2_W-1:0]    nn2;   // 2*N*N
        logic [LEVELS_W-1:0] lv;    // clamped level count
        logic [CHAN_W-1:0]   dm1;   // lv - 1
    } odrgb_side_t;

endpackage

>>> rtl/ordered_dither_rgb_top.sv
// Ordered (Bayer) multilevel dithering of one RGB pixel word per clock.
// A word accepted at a rising edge passes the input register, the lane stages
// and the merge register; its result then shows, with done high, for exactly one cycle.
// Throughput: one word per cycle; busy is always low and the receiver cannot stall.
// Reset (rst_n, asynchronous, active low) empties the pipeline and sets the
// map size to 2x2 and the level count to 2.
module ordered_dither_rgb_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  odrgb_pkg::odrgb_pixel_t             pixel,
    output logic                                done,
    output odrgb_pkg::odrgb_result_t            result,
    input  logic                                cfg_we,
    input  logic [odrgb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [odrgb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import odrgb_pkg::*;

    // Pipeline overview. The input stage latches the pixel word together with
    // the threshold taken from the map at (row mod N, column mod N) and the
    // clamped level count. Three identical channel lanes then run five stages
    // each: the product v*L, the split by 255 into quotient and remainder, the
    // threshold compare with clamp to L-1, and two stages of a restoring
    // divider that rescales q*255 by L-1. A final merge register gathers the
    // three lanes into the result word and raises done.

    localparam int LANE_STAGES = 5;

    logic [1:0]          map_size_reg;
    logic [LEVELS_W-1:0] levels_reg;

    logic [LANE_STAGES:0] vld_reg, vld_next;
    odrgb_pixel_t         pix_reg;
    odrgb_side_t          side_reg, side_next;
    odrgb_result_t        result_reg, result_next;
    logic                 done_reg;

    logic                 accept;
    logic [LEVELS_W-1:0]  lv_clamped;

    // The block never refuses a word: every stage advances each cycle.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Configuration writes land directly in the registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_size_reg <= MAP_2X2;
            levels_reg   <= 9'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAP_SIZE: map_size_reg <= cfg_data[1:0];
                CFG_LEVELS:   levels_reg   <= cfg_data[LEVELS_W-1:0];
                default:      ;
            endcase
        end
    end

    // Level counts outside 2..256 are pinned to the nearest end.
    always_comb
    begin
        if (levels_reg < 9'd2)
        begin
            lv_clamped = 9'd2;
        end
        else if (levels_reg > 9'd256)
        begin
            lv_clamped = 9'd256;
        end
        else
        begin
            lv_clamped = levels_reg;
        end
    end

    odrgb_thr u_thr (
        .column  (pixel.pixel_column),
        .row     (pixel.pixel_row),
        .map_sel (map_size_reg),
        .thr     (side_next.thr),
        .nn2     (side_next.nn2)
    );

    assign side_next.lv  = lv_clamped;
    assign side_next.dm1 = 8'(lv_clamped - 9'd1);

    // Valid bits follow each word down the lanes; the payload needs no reset.
    assign vld_next = {vld_reg[LANE_STAGES-1:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[LANE_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg  <= pixel;
            side_reg <= side_next;
        end
    end

    odrgb_lane u_lane_red (
        .clk    (clk),
        .value  (pix_reg.red_in),
        .side   (side_reg),
        .result (result_next.red_out)
    );

    odrgb_lane u_lane_green (
        .clk    (clk),
        .value  (pix_reg.green_in),
        .side   (side_reg),
        .result (result_next.green_out)
    );

    odrgb_lane u_lane_blue (
        .clk    (clk),
        .value  (pix_reg.blue_in),
        .side   (side_reg),
        .result (result_next.blue_out)
    );

    // Merge stage: the three lane results become one result word.
    always_ff @(posedge clk)
    begin
        if (vld_reg[LANE_STAGES])
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/odrgb_thr.sv
module odrgb_thr (
    input  logic [odrgb_pkg::COORD_W-1:0] column,
    input  logic [odrgb_pkg::COORD_W-1:0] row,
    input  logic [1:0]                    map_sel,
    output logic [odrgb_pkg::THR_W-1:0]   thr,
    output logic [odrgb_pkg::NN2_W-1:0]   nn2
);
    import odrgb_pkg::*;

    localparam int PAIRS = (COORD_W + 1) / 2;

    // Residue mod 3 from the sum of base-4 digits, since 4 is 1 mod 3.
    function automatic logic [1:0] mod3(input logic [COORD_W-1:0] x);
        logic [2*PAIRS-1:0] xp;
        logic [4:0]         s;
        logic [2:0]         s2;
        logic [2:0]         s3;
        xp = (2*PAIRS)'(x);
        s  = '0;
        for (int i = 0; i < PAIRS; i++)
        begin
            s = s + 5'(xp[2*i +: 2]);
        end
        s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        if (s3 >= 3'd3)
        begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

    // Residue mod 6 joins the parity and the residue mod 3.
    function automatic logic [2:0] mod6(input logic [COORD_W-1:0] x);
        logic [1:0] m3;
        m3 = mod3(x);
        return (m3[0] == x[0]) ? 3'(m3) : 3'(m3) + 3'd3;
    endfunction

    logic [COORD_W-1:0] col_m;
    logic [COORD_W-1:0] row_m;
    logic [2:0]         col_idx;
    logic [2:0]         row_idx;

    assign col_m = column & COORD_MASK;
    assign row_m = row & COORD_MASK;

    always_comb
    begin
        case (map_sel)
            MAP_3X3:
            begin
                col_idx = 3'(mod3(col_m));
                row_idx = 3'(mod3(row_m));
                nn2     = 7'd18;
            end
            MAP_4X4:
            begin
                col_idx = 3'(col_m[1:0]);
                row_idx = 3'(row_m[1:0]);
                nn2     = 7'd32;
            end
            MAP_6X6:
            begin
                col_idx = mod6(col_m);
                row_idx = mod6(row_m);
                nn2     = 7'd72;
            end
            default:
            begin
                col_idx = 3'(col_m[0]);
                row_idx = 3'(row_m[0]);
                nn2     = 7'd8;
            end
        endcase
    end

    assign thr = THR_TAB[map_sel][row_idx][col_idx];

endmodule

>>> rtl/odrgb_lane.sv
module odrgb_lane (
    input  logic                         clk,
    input  logic [odrgb_pkg::CHAN_W-1:0] value,
    input  odrgb_pkg::odrgb_side_t       side,
    output logic [odrgb_pkg::CHAN_W-1:0] result
);
    import odrgb_pkg::*;

    // Stage 1: product v * L.
    logic [15:0]  prod_reg, prod_next;
    odrgb_side_t  s1_side_reg;

    // Stage 2: quotient and remainder of the product by 255.
    logic [8:0]   q_reg, q_next;
    logic [7:0]   r_reg, r_next;
    odrgb_side_t  s2_side_reg;

    // Stage 3: threshold bump and clamp to L-1.
    logic [7:0]   qc_reg, qc_next;
    logic [7:0]   s3_dm1_reg;

    // Stages 4 and 5: q*255 / (L-1), four quotient bits per stage.
    logic [7:0]   rem_reg, rem_next;
    logic [3:0]   qh_reg, qh_next;
    logic [3:0]   xl_reg, xl_next;
    logic [7:0]   s4_dm1_reg;
    logic [7:0]   result_reg, result_next;

    logic [8:0]   q_est;
    logic [8:0]   r_est;
    logic         r_wrap;
    logic [14:0]  lhs;
    logic [14:0]  rhs;
    logic [6:0]   odd_thr;
    logic [8:0]   q_bump;
    logic [15:0]  scaled;

    assign prod_next = 16'(value) * 16'(side.lv);

    // prod/256 undershoots prod/255 by at most one, so one correction suffices.
    assign q_est  = 9'(prod_reg[15:8]);
    assign r_est  = 9'(prod_reg[7:0]) + q_est;
    assign r_wrap = (r_est >= 9'd255);
    assign q_next = q_est + 9'(r_wrap);
    assign r_next = r_wrap ? 8'(r_est - 9'd255) : r_est[7:0];

    assign lhs     = 15'(s2_side_reg.nn2) * 15'(r_reg);
    assign odd_thr = {s2_side_reg.thr, 1'b1};
    assign rhs     = (15'(odd_thr) << 8) - 15'(odd_thr);
    assign q_bump  = q_reg + 9'(lhs > rhs);
    assign qc_next = (q_bump > 9'(s2_side_reg.dm1)) ? s2_side_reg.dm1 : q_bump[7:0];

    assign scaled = (16'(qc_reg) << 8) - 16'(qc_reg);

    always_comb
    begin
        logic [8:0] trial;
        logic [7:0] rem;
        rem = scaled[15:8];
        for (int i = 7; i >= 4; i--)
        begin
            trial = {rem, scaled[i]};
            if (trial >= {1'b0, s3_dm1_reg})
            begin
                rem            = 8'(trial - {1'b0, s3_dm1_reg});
                qh_next[i - 4] = 1'b1;
            end
            else
            begin
                rem            = trial[7:0];
                qh_next[i - 4] = 1'b0;
            end
        end
        rem_next = rem;
    end

    assign xl_next = scaled[3:0];

    always_comb
    begin
        logic [8:0] trial;
        logic [7:0] rem;
        logic [3:0] ql;
        rem = rem_reg;
        for (int i = 3; i >= 0; i--)
        begin
            trial = {rem, xl_reg[i]};
            if (trial >= {1'b0, s4_dm1_reg})
            begin
                rem   = 8'(trial - {1'b0, s4_dm1_reg});
                ql[i] = 1'b1;
            end
            else
            begin
                rem   = trial[7:0];
                ql[i] = 1'b0;
            end
        end
        result_next = {qh_reg, ql};
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        s1_side_reg <= side;
        q_reg       <= q_next;
        r_reg       <= r_next;
        s2_side_reg <= s1_side_reg;
        qc_reg      <= qc_next;
        s3_dm1_reg  <= s2_side_reg.dm1;
        rem_reg     <= rem_next;
        qh_reg      <= qh_next;
        xl_reg      <= xl_next;
        s4_dm1_reg  <= s3_dm1_reg;
        result_reg  <= result_next;
    end

    assign result = result_reg;

endmodule

>>> rtl/odrgb_chk.sv
module odrgb_chk (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  odrgb_pkg::odrgb_result_t            result
);
    import odrgb_pkg::*;

    // The pipeline never holds off a word.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every accepted word yields a result with done high.
    a_word_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("accepted word produced no result");

    // No result appears without an earlier accepted word.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 7))
        else $error("result without an accepted word");

    // A result word carries no unknown bits while done is high.
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(result))
        else $error("result word has unknown bits");

endmodule

bind ordered_dither_rgb_top odrgb_chk u_odrgb_chk (.*);
